>>> sv/qfr_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion frame rotation package
// Request and result types and the fixed field widths shared by the design.
// ----------------------------------------------------------------------------
package qfr_pkg;

    // Field widths of the quaternion and vector components.
    localparam int QUAT_W = 16;
    localparam int VEC_W  = 16;

    // Rotation directions carried in the operation field.
    localparam logic OP_BODY_TO_EARTH = 1'b0;
    localparam logic OP_EARTH_TO_BODY = 1'b1;

    // One rotation request.
    typedef struct packed {
        logic                     operation;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [VEC_W-1:0]  vec_x;
        logic signed [VEC_W-1:0]  vec_y;
        logic signed [VEC_W-1:0]  vec_z;
    } req_t;

    // One rotated vector with its saturation flag.
    typedef struct packed {
        logic signed [VEC_W-1:0] out_x;
        logic signed [VEC_W-1:0] out_y;
        logic signed [VEC_W-1:0] out_z;
        logic                    clipped;
    } res_t;

endpackage

>>> sv/quaternion_frame_rotation.sv
// ----------------------------------------------------------------------------
// Quaternion frame rotation
// Rotates a vector between body and earth frames with the rotation matrix of
// an attitude quaternion, rounding to nearest and saturating each component.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle, set by a five-stage pipeline (quaternion
// products, matrix, matrix-vector products, row sums, round and saturate);
// done is the valid bit of the last stage. busy is always low and the
// receiver cannot stall.
// Reset clears only the valid bits; data registers are not reset.
module quaternion_frame_rotation #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  qfr_pkg::req_t request,
    output logic          done,
    output qfr_pkg::res_t result
);
    import qfr_pkg::*;

    // Arithmetic widths.
    localparam int SHIFT  = 2 * QUAT_FRAC_BITS;
    localparam int P_W    = 2 * QUAT_W;
    localparam int M_W    = P_W + 2;
    localparam int PROD_W = M_W + VEC_W;
    localparam int SUM_W  = ((SHIFT + 1) > (PROD_W + 2)) ? SHIFT + 2 : PROD_W + 3;
    localparam int Q_W    = SUM_W - SHIFT;
    localparam int R_W    = ((Q_W > VEC_W) ? Q_W : VEC_W) + 1;

    localparam logic signed [SUM_W-1:0] ROUND_C =
        {{(SUM_W - SHIFT){1'b0}}, 1'b1, {(SHIFT - 1){1'b0}}};
    localparam logic signed [R_W-1:0] SAT_MAX =
        {{(R_W - VEC_W + 1){1'b0}}, {(VEC_W - 1){1'b1}}};
    localparam logic signed [R_W-1:0] SAT_MIN =
        {{(R_W - VEC_W + 1){1'b1}}, {(VEC_W - 1){1'b0}}};

    // The pipeline never holds off a request.
    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    // Valid bits of the stages.
    logic v1_reg, v2_reg, v3_reg, v4_reg, done_reg;

    // Stage 1: quaternion component products.
    logic signed [P_W-1:0]   xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [P_W-1:0]   wx_reg, wy_reg, wz_reg;
    logic                    op1_reg;
    logic signed [VEC_W-1:0] vec1_reg [3];

    // Stage 2: matrix entries, already transposed for the requested direction.
    logic signed [M_W-1:0]   m_next   [3][3];
    logic signed [M_W-1:0]   mat_next [3][3];
    logic signed [M_W-1:0]   mat_reg  [3][3];
    logic signed [VEC_W-1:0] vec2_reg [3];

    // Stage 3: matrix-vector products.
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic signed [VEC_W-1:0]  vec3_reg  [3];

    // Stage 4: row sums with the rounding constant.
    logic signed [SUM_W-1:0] sum_next [3];
    logic signed [SUM_W-1:0] sum_reg  [3];
    logic signed [VEC_W-1:0] vec4_reg [3];

    // Stage 5: floor shift, add the identity part, saturate.
    logic signed [Q_W-1:0]   quo      [3];
    logic signed [R_W-1:0]   raw      [3];
    logic signed [VEC_W-1:0] sat_next [3];
    logic [2:0]              clip_bit;
    res_t                    result_next;
    res_t                    result_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // Stage 1 registers.
    always_ff @(posedge clk)
    begin
        xx_reg      <= request.quat_x * request.quat_x;
        yy_reg      <= request.quat_y * request.quat_y;
        zz_reg      <= request.quat_z * request.quat_z;
        xy_reg      <= request.quat_x * request.quat_y;
        xz_reg      <= request.quat_x * request.quat_z;
        yz_reg      <= request.quat_y * request.quat_z;
        wx_reg      <= request.quat_w * request.quat_x;
        wy_reg      <= request.quat_w * request.quat_y;
        wz_reg      <= request.quat_w * request.quat_z;
        op1_reg     <= request.operation;
        vec1_reg[0] <= request.vec_x;
        vec1_reg[1] <= request.vec_y;
        vec1_reg[2] <= request.vec_z;
    end

    // Body-to-earth matrix scaled by two to the power 2F, identity removed.
    always_comb
    begin
        m_next[0][0] = -((M_W'(yy_reg) + M_W'(zz_reg)) <<< 1);
        m_next[0][1] = (M_W'(xy_reg) - M_W'(wz_reg)) <<< 1;
        m_next[0][2] = (M_W'(xz_reg) + M_W'(wy_reg)) <<< 1;
        m_next[1][0] = (M_W'(xy_reg) + M_W'(wz_reg)) <<< 1;
        m_next[1][1] = -((M_W'(xx_reg) + M_W'(zz_reg)) <<< 1);
        m_next[1][2] = (M_W'(yz_reg) - M_W'(wx_reg)) <<< 1;
        m_next[2][0] = (M_W'(xz_reg) - M_W'(wy_reg)) <<< 1;
        m_next[2][1] = (M_W'(yz_reg) + M_W'(wx_reg)) <<< 1;
        m_next[2][2] = -((M_W'(xx_reg) + M_W'(yy_reg)) <<< 1);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mat_next[i][j] = (op1_reg == OP_EARTH_TO_BODY) ? m_next[j][i]
                                                                : m_next[i][j];
            end
        end
    end

    // Stage 2 registers.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mat_reg[i][j] <= mat_next[i][j];
            end
            vec2_reg[i] <= vec1_reg[i];
        end
    end

    // Each matrix entry times its vector component.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i][j] = PROD_W'(mat_reg[i][j]) * PROD_W'(vec2_reg[j]);
            end
        end
    end

    // Stage 3 registers.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[i][j] <= prod_next[i][j];
            end
            vec3_reg[i] <= vec2_reg[i];
        end
    end

    // Row sums plus one half for round to nearest.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = SUM_W'(prod_reg[i][0]) + SUM_W'(prod_reg[i][1])
                        + SUM_W'(prod_reg[i][2]) + ROUND_C;
        end
    end

    // Stage 4 registers.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_reg[i]  <= sum_next[i];
            vec4_reg[i] <= vec3_reg[i];
        end
    end

    // Dropping the low bits floors the sum; the input adds the identity part.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quo[i] = sum_reg[i][SUM_W-1:SHIFT];
            raw[i] = R_W'(quo[i]) + R_W'(vec4_reg[i]);
            if (raw[i] > SAT_MAX)
            begin
                sat_next[i] = SAT_MAX[VEC_W-1:0];
                clip_bit[i] = 1'b1;
            end
            else if (raw[i] < SAT_MIN)
            begin
                sat_next[i] = SAT_MIN[VEC_W-1:0];
                clip_bit[i] = 1'b1;
            end
            else
            begin
                sat_next[i] = raw[i][VEC_W-1:0];
                clip_bit[i] = 1'b0;
            end
        end
        result_next.out_x   = sat_next[0];
        result_next.out_y   = sat_next[1];
        result_next.out_z   = sat_next[2];
        result_next.clipped = |clip_bit;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> bench/tb_quaternion_frame_rotation.sv
// ----------------------------------------------------------------------------
// Quaternion frame rotation testbench
// Drives rotation requests through the command handshake and checks every
// rotated vector against a behavioral predictor kept inside the bench. A
// short table of directed requests comes first, then random requests under
// several idle patterns of the sender. A watchdog ends a run that stops
// moving.
// ----------------------------------------------------------------------------
module tb_quaternion_frame_rotation;

    import qfr_pkg::*;

    localparam int FRAC_BITS       = 14;
    localparam int PIPE_LATENCY    = 5;
    localparam int STALL_LIMIT     = 1000;
    localparam int RANDOM_REQUESTS = 450;
    localparam int PHASE_COUNT     = 4;

    // One row of the directed table; typed rows carry a hand-computed result.
    typedef struct packed {
        req_t stim;
        res_t golden;
        logic typed;
    } directed_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    req_t request = '0;
    res_t result;

    // Expectation that travels with the request currently on the inputs.
    res_t request_rotation = '0;

    res_t          expected_rotations[$];
    directed_row_t directed_rows[$];
    int            error_count  = 0;
    int            quiet_cycles = 0;

    quaternion_frame_rotation #(
        .QUAT_FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    // Free-running clock with a period of ten.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Rotates the request vector with the quaternion matrix, or its
    // transpose, then rounds to nearest and saturates each component.
    function automatic res_t rotate_vector(req_t r);
        longint     qw, qx, qy, qz;
        longint     v[3];
        longint     m[3][3];
        longint     acc, comp;
        logic [15:0] o[3];
        logic       clip;
        res_t       res;
        qw = longint'($signed(r.quat_w));
        qx = longint'($signed(r.quat_x));
        qy = longint'($signed(r.quat_y));
        qz = longint'($signed(r.quat_z));
        v[0] = longint'($signed(r.vec_x));
        v[1] = longint'($signed(r.vec_y));
        v[2] = longint'($signed(r.vec_z));
        // Matrix scaled by 2^(2F) with the identity part taken out.
        m[0][0] = -2 * (qy * qy + qz * qz);
        m[0][1] =  2 * (qx * qy - qw * qz);
        m[0][2] =  2 * (qx * qz + qw * qy);
        m[1][0] =  2 * (qx * qy + qw * qz);
        m[1][1] = -2 * (qx * qx + qz * qz);
        m[1][2] =  2 * (qy * qz - qw * qx);
        m[2][0] =  2 * (qx * qz - qw * qy);
        m[2][1] =  2 * (qy * qz + qw * qx);
        m[2][2] = -2 * (qx * qx + qy * qy);
        clip = 1'b0;
        for (int row = 0; row < 3; row++)
        begin
            acc = 0;
            for (int col = 0; col < 3; col++)
            begin
                if (r.operation == OP_EARTH_TO_BODY)
                    acc += m[col][row] * v[col];
                else
                    acc += m[row][col] * v[col];
            end
            // Half an LSB, then an arithmetic shift gives round half up.
            acc += longint'(1) <<< (2 * FRAC_BITS - 1);
            comp = v[row] + (acc >>> (2 * FRAC_BITS));
            if (comp > 32767)
            begin
                comp = 32767;
                clip = 1'b1;
            end
            if (comp < -32768)
            begin
                comp = -32768;
                clip = 1'b1;
            end
            o[row] = comp[15:0];
        end
        res.out_x   = o[0];
        res.out_y   = o[1];
        res.out_z   = o[2];
        res.clipped = clip;
        return res;
    endfunction

    function automatic req_t make_req(logic op, int w, int x, int y, int z,
                                      int vx, int vy, int vz);
        req_t r;
        r.operation = op;
        r.quat_w    = w[15:0];
        r.quat_x    = x[15:0];
        r.quat_y    = y[15:0];
        r.quat_z    = z[15:0];
        r.vec_x     = vx[15:0];
        r.vec_y     = vy[15:0];
        r.vec_z     = vz[15:0];
        return r;
    endfunction

    function automatic res_t make_res(int x, int y, int z, logic clip);
        res_t r;
        r.out_x   = x[15:0];
        r.out_y   = y[15:0];
        r.out_z   = z[15:0];
        r.clipped = clip;
        return r;
    endfunction

    function automatic void add_row(req_t stim, res_t golden, logic typed);
        directed_row_t row;
        row.stim   = stim;
        row.golden = golden;
        row.typed  = typed;
        directed_rows.push_back(row);
    endfunction

    // Picks a random vector component, full range or small.
    function automatic int random_component();
        if ($urandom_range(1) == 0)
            return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(2000)) - 1000;
    endfunction

    // Picks an extreme or landmark quaternion component.
    function automatic int landmark_component();
        case ($urandom_range(4))
            0: return -32768;
            1: return 32767;
            2: return 16384;
            3: return -16384;
            default: return 0;
        endcase
    endfunction

    // Random request: half unit quaternions, the rest raw or extreme ones.
    function automatic req_t random_request();
        real  a, b, c, d, norm;
        int   w, x, y, z;
        logic op;
        int   mode;
        op   = $urandom_range(1) ? OP_EARTH_TO_BODY : OP_BODY_TO_EARTH;
        mode = $urandom_range(3);
        if (mode == 0)
        begin
            w = int'($urandom_range(65535)) - 32768;
            x = int'($urandom_range(65535)) - 32768;
            y = int'($urandom_range(65535)) - 32768;
            z = int'($urandom_range(65535)) - 32768;
        end
        else if (mode == 3)
        begin
            w = landmark_component();
            x = landmark_component();
            y = landmark_component();
            z = landmark_component();
        end
        else
        begin
            a = real'(int'($urandom_range(32768)) - 16384);
            b = real'(int'($urandom_range(32768)) - 16384);
            c = real'(int'($urandom_range(32768)) - 16384);
            d = real'(int'($urandom_range(32768)) - 16384);
            norm = $sqrt(a * a + b * b + c * c + d * d);
            if (norm == 0.0)
            begin
                a = 1.0;
                norm = 1.0;
            end
            w = $rtoi(a / norm * 16384.0);
            x = $rtoi(b / norm * 16384.0);
            y = $rtoi(c / norm * 16384.0);
            z = $rtoi(d / norm * 16384.0);
        end
        return make_req(op, w, x, y, z, random_component(), random_component(),
                        random_component());
    endfunction

    // Compares one rotated vector with the oldest expectation.
    task automatic check_rotation(res_t got);
        res_t want;
        if (expected_rotations.size() == 0)
        begin
            $error("result with no request outstanding: x=%0d y=%0d z=%0d clipped=%0b",
                   $signed(got.out_x), $signed(got.out_y), $signed(got.out_z),
                   got.clipped);
            error_count++;
        end
        else
        begin
            want = expected_rotations.pop_front();
            if (got.out_x !== want.out_x)
            begin
                $error("out_x: expected %0d, actual %0d",
                       $signed(want.out_x), $signed(got.out_x));
                error_count++;
            end
            if (got.out_y !== want.out_y)
            begin
                $error("out_y: expected %0d, actual %0d",
                       $signed(want.out_y), $signed(got.out_y));
                error_count++;
            end
            if (got.out_z !== want.out_z)
            begin
                $error("out_z: expected %0d, actual %0d",
                       $signed(want.out_z), $signed(got.out_z));
                error_count++;
            end
            if (got.clipped !== want.clipped)
            begin
                $error("clipped: expected %0b, actual %0b", want.clipped, got.clipped);
                error_count++;
            end
        end
    endtask

    // Records accepted requests, checks results and watches for a stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_rotations.push_back(request_rotation);
            if (done)
                check_rotation(result);
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Issues one request after a random idle gap and waits until accepted.
    task automatic send_request(req_t r, res_t want, int idle_pct);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        request          <= r;
        request_rotation <= want;
        start            <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Holds off new requests until every outstanding result has come back.
    task automatic drain_requests();
        start <= 1'b0;
        @(posedge clk);
        while (expected_rotations.size() != 0)
            @(posedge clk);
    endtask

    // Main sequence: reset, directed table, random phases, final check.
    initial
    begin
        int   idle_pct[PHASE_COUNT];
        req_t r;
        idle_pct[0] = 0;
        idle_pct[1] = 57;
        idle_pct[2] = 0;
        idle_pct[3] = 36;

        // Identity and zero quaternions leave the vector as it is.
        add_row(make_req(OP_BODY_TO_EARTH, 16384, 0, 0, 0, 100, -200, 300),
                make_res(100, -200, 300, 1'b0), 1'b1);
        add_row(make_req(OP_EARTH_TO_BODY, 16384, 0, 0, 0, 32767, -32768, 0),
                make_res(32767, -32768, 0, 1'b0), 1'b1);
        add_row(make_req(OP_BODY_TO_EARTH, 0, 0, 0, 0, -32768, 32767, -1),
                make_res(-32768, 32767, -1, 1'b0), 1'b1);
        // Half turns negate two axes; negating -32768 saturates.
        add_row(make_req(OP_BODY_TO_EARTH, 0, 0, 0, 16384, -32768, 5, 7),
                make_res(32767, -5, 7, 1'b1), 1'b1);
        add_row(make_req(OP_EARTH_TO_BODY, 0, 0, 0, 16384, 1, -32768, 0),
                make_res(-1, 32767, 0, 1'b1), 1'b1);
        add_row(make_req(OP_EARTH_TO_BODY, 0, 16384, 0, 0, 10, 20, -30),
                make_res(10, -20, 30, 1'b0), 1'b1);
        add_row(make_req(OP_BODY_TO_EARTH, 0, 0, 16384, 0, -32768, -32768, -32768),
                make_res(32767, -32768, 32767, 1'b1), 1'b1);
        // Exact halves round toward plus infinity.
        add_row(make_req(OP_BODY_TO_EARTH, 0, 0, 0, 8192, 1, -1, 3),
                make_res(1, 0, 3, 1'b0), 1'b1);
        // Remaining rows are left to the predictor.
        add_row(make_req(OP_EARTH_TO_BODY, -16384, 0, 0, 0, -7, 8, -9), '0, 1'b0);
        add_row(make_req(OP_BODY_TO_EARTH, 11585, 0, 0, 11585, 1000, 0, 0), '0, 1'b0);
        add_row(make_req(OP_EARTH_TO_BODY, 11585, 0, 0, 11585, 1000, 0, 0), '0, 1'b0);
        add_row(make_req(OP_BODY_TO_EARTH, 11585, 0, 11585, 0, 0, 0, -20000), '0, 1'b0);
        add_row(make_req(OP_BODY_TO_EARTH, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768), '0, 1'b0);
        add_row(make_req(OP_EARTH_TO_BODY, 32767, 32767, 32767, 32767,
                         32767, 32767, 32767), '0, 1'b0);
        add_row(make_req(OP_BODY_TO_EARTH, -32768, 32767, -32768, 32767,
                         32767, -32768, 32767), '0, 1'b0);
        add_row(make_req(OP_BODY_TO_EARTH, 8192, 8192, 8192, 8192,
                         12345, -23456, 345), '0, 1'b0);
        add_row(make_req(OP_EARTH_TO_BODY, 8192, 8192, 8192, 8192,
                         12345, -23456, 345), '0, 1'b0);
        // Non-unit quaternion, used without normalization.
        add_row(make_req(OP_EARTH_TO_BODY, 100, -200, 300, -400, -1, -1, -1), '0, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].stim,
                         directed_rows[i].typed ? directed_rows[i].golden
                                                : rotate_vector(directed_rows[i].stim),
                         0);
        end
        drain_requests();

        // Random requests, one idle pattern per phase, pipeline drained between.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            for (int n = 0; n < RANDOM_REQUESTS / PHASE_COUNT; n++)
            begin
                r = random_request();
                send_request(r, rotate_vector(r), idle_pct[phase]);
            end
            drain_requests();
        end

        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/qfr_pkg.sv
sv/quaternion_frame_rotation.sv
bench/tb_quaternion_frame_rotation.sv
